[rtl/biq_pkg.sv]
// Shared types for the biquad filter: multiplier operand selects and the
// command word that the controller sends to the datapath. No dependencies.
`default_nettype none

package biq_pkg;

  // Register indexes of the coefficient port.
  localparam logic [2:0] RegB0 = 3'd0;
  localparam logic [2:0] RegB1 = 3'd1;
  localparam logic [2:0] RegB2 = 3'd2;
  localparam logic [2:0] RegA1 = 3'd3;
  localparam logic [2:0] RegA2 = 3'd4;

  // Operand pair fed to the shared multiplier.
  typedef enum logic [2:0] {
    MUL_XB0 = 3'd0,
    MUL_XB1 = 3'd1,
    MUL_XB2 = 3'd2,
    MUL_A1Y = 3'd3,
    MUL_A2Y = 3'd4
  } mul_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     ld_x;      // capture the input sample
    logic     mul_en;    // register a new product
    mul_sel_e mul_sel;   // operands of that product
    logic     ld_acc;    // acc = x*b0 + delay_one
    logic     ld_t1;     // x*b1 + delay_two
    logic     ld_t2;     // x*b2
    logic     ld_n1;     // new delay_one before commit
    logic     commit;    // update delays and load the result word
    logic     clear;     // zero delays and load a zero result word
  } biq_cmd_t;

endpackage

`default_nettype wire

[rtl/biq_datapath.sv]
// Biquad datapath: coefficient registers, delay registers, one shared
// 32x32 multiplier with a product register, and the result word register.
// Depends on biq_pkg.
`default_nettype none

module biq_datapath
  import biq_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire biq_cmd_t           cmd_i,
  input  wire logic signed [15:0] sample_i,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_addr_i,
  input  wire logic [31:0]        cfg_wdata_i,
  output logic signed [15:0]      sample_o,
  output logic                    sat_o
);

  // Clamp a 42-bit value to the 40-bit delay range.
  function automatic logic [39:0] clamp40(input logic [41:0] v);
    logic ovf;
    ovf = !((&v[41:39]) || !(|v[41:39]));
    if (!ovf) begin
      clamp40 = v[39:0];
    end else if (v[41]) begin
      clamp40 = {1'b1, 39'd0};
    end else begin
      clamp40 = {1'b0, {39{1'b1}}};
    end
  endfunction

  function automatic logic ovf40(input logic [41:0] v);
    ovf40 = !((&v[41:39]) || !(|v[41:39]));
  endfunction

  logic signed [31:0] coef_b0_q, coef_b1_q, coef_b2_q, coef_a1_q, coef_a2_q;
  logic signed [39:0] d1_q, d2_q;
  logic signed [15:0] x_q;
  logic signed [63:0] prod_q;
  logic signed [40:0] acc_q;
  logic signed [40:0] t1_q;
  logic signed [34:0] t2_q;
  logic signed [39:0] n1_q;
  logic               n1_sat_q;
  logic signed [15:0] out_q;
  logic               out_sat_q;

  logic signed [31:0] op_a, op_b, y_w;
  logic signed [63:0] prod_d, r13_full, r29_full;
  logic signed [34:0] r13_w, r29_w;
  logic signed [41:0] n1_full, n2_full, s_full;
  logic signed [25:0] s_shift;
  logic signed [15:0] s_clamp;
  logic               s_ovf;
  logic               cfg_hit;

  // Coefficient writes; any write to a defined register clears the state.
  assign cfg_hit = cfg_we_i && (cfg_addr_i == RegB0 || cfg_addr_i == RegB1 ||
                   cfg_addr_i == RegB2 || cfg_addr_i == RegA1 ||
                   cfg_addr_i == RegA2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_b0_q <= 32'sh2000_0000;
      coef_b1_q <= '0;
      coef_b2_q <= '0;
      coef_a1_q <= '0;
      coef_a2_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        RegB0:   coef_b0_q <= cfg_wdata_i;
        RegB1:   coef_b1_q <= cfg_wdata_i;
        RegB2:   coef_b2_q <= cfg_wdata_i;
        RegA1:   coef_a1_q <= cfg_wdata_i;
        RegA2:   coef_a2_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Feedback operand: acc limited to the 32-bit signed range.
  always_comb begin
    if (acc_q[40] && !(&acc_q[40:31])) begin
      y_w = 32'sh8000_0000;
    end else if (!acc_q[40] && (|acc_q[40:31])) begin
      y_w = 32'sh7fff_ffff;
    end else begin
      y_w = acc_q[31:0];
    end
  end

  // Shared multiplier operand selection.
  always_comb begin
    case (cmd_i.mul_sel)
      MUL_XB0: begin op_a = 32'(x_q); op_b = coef_b0_q; end
      MUL_XB1: begin op_a = 32'(x_q); op_b = coef_b1_q; end
      MUL_XB2: begin op_a = 32'(x_q); op_b = coef_b2_q; end
      MUL_A1Y: begin op_a = coef_a1_q; op_b = y_w; end
      MUL_A2Y: begin op_a = coef_a2_q; op_b = y_w; end
      default: begin op_a = '0; op_b = '0; end
    endcase
    prod_d = op_a * op_b;
  end

  // Rounded rescaling of the registered product to delay scale.
  always_comb begin
    r13_full = (prod_q + 64'sd4096) >>> 13;
    r29_full = (prod_q + 64'sd268435456) >>> 29;
    r13_w    = r13_full[34:0];
    r29_w    = r29_full[34:0];
    n1_full  = 42'(t1_q) - 42'(r29_w);
    n2_full  = 42'(t2_q) - 42'(r29_w);
  end

  // Output sample: acc rounded to 16 bits and saturated.
  always_comb begin
    s_full  = 42'(acc_q) + 42'sd32768;
    s_shift = 26'(s_full >>> 16);
    s_ovf   = !((&s_shift[25:15]) || !(|s_shift[25:15]));
    if (!s_ovf) begin
      s_clamp = s_shift[15:0];
    end else if (s_shift[25]) begin
      s_clamp = 16'sh8000;
    end else begin
      s_clamp = 16'sh7fff;
    end
  end

  // Working registers of one filter step.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_x) begin
      x_q <= sample_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.ld_acc) begin
      acc_q <= 41'(r13_w) + 41'(d1_q);
    end
    if (cmd_i.ld_t1) begin
      t1_q <= 41'(r13_w) + 41'(d2_q);
    end
    if (cmd_i.ld_t2) begin
      t2_q <= r13_w;
    end
    if (cmd_i.ld_n1) begin
      n1_q     <= clamp40(n1_full);
      n1_sat_q <= ovf40(n1_full);
    end
  end

  // Delay state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_q <= '0;
      d2_q <= '0;
    end else if (cfg_hit || cmd_i.clear) begin
      d1_q <= '0;
      d2_q <= '0;
    end else if (cmd_i.commit) begin
      d1_q <= n1_q;
      d2_q <= clamp40(n2_full);
    end
  end

  // Result word register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      out_q     <= '0;
      out_sat_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_q     <= s_clamp;
      out_sat_q <= s_ovf || n1_sat_q || ovf40(n2_full);
    end
  end

  assign sample_o = out_q;
  assign sat_o    = out_sat_q;

endmodule

`default_nettype wire

[rtl/biq_ctrl.sv]
// Biquad controller: one-hot sequencer over the shared multiplier steps and
// the valid flag of the result word register. Depends on biq_pkg.
`default_nettype none

module biq_ctrl
  import biq_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic in_mode_i,
  output logic      in_ready_o,
  input  wire logic out_ready_i,
  output logic      out_valid_o,
  output biq_cmd_t  cmd_o
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_MB0  = 8'b0000_0010,
    ST_MB1  = 8'b0000_0100,
    ST_MB2  = 8'b0000_1000,
    ST_MA1  = 8'b0001_0000,
    ST_MA2  = 8'b0010_0000,
    ST_FIN  = 8'b0100_0000,
    ST_CLR  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // The result register can take a new word when empty or being drained.
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_XB0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.ld_x = 1'b1;
          state_d    = in_mode_i ? ST_CLR : ST_MB0;
        end
      end
      ST_MB0: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_XB0;
        state_d       = ST_MB1;
      end
      ST_MB1: begin
        cmd_o.ld_acc  = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_XB1;
        state_d       = ST_MB2;
      end
      ST_MB2: begin
        cmd_o.ld_t1   = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_XB2;
        state_d       = ST_MA1;
      end
      ST_MA1: begin
        cmd_o.ld_t2   = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_A1Y;
        state_d       = ST_MA2;
      end
      ST_MA2: begin
        cmd_o.ld_n1   = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_A2Y;
        state_d       = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_CLR: begin
        if (out_free) begin
          cmd_o.clear = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result valid: set when a word is loaded, dropped when it is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit || cmd_o.clear) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[rtl/biquad_iir_filter.sv]
// Top level of the biquad IIR filter (transposed direct form II).
// Instantiates biq_ctrl and biq_datapath; depends on biq_pkg.
//
//   channel   direction  tdata             tuser
//   s_axis    in         [15:0] sample_in  [0] mode (1 = clear state)
//   m_axis    out        [15:0] sample_out [0] saturated
//   cfg       in         cfg_wdata_i[31:0] to register cfg_addr_i (0..4)
//
// A filter word steps through MB0, MB1, MB2, MA1 and MA2, one state for each
// of the five products on the shared 32x32 multiplier, and FIN loads the result
// register; a clear word goes through CLR alone. A new word is accepted in the
// cycle after the previous result is loaded, so none is taken while one is in work.
// If the result register is still full, the step holds in its last state.
// Reset loads b0 = 1.0, clears the other coefficients and both delays.
`default_nettype none

module biquad_iir_filter
  import biq_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input words.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] sample_in
  input  wire logic [0:0]  s_axis_tuser,   // [0] mode
  // Result words.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [15:0] sample_out
  output logic [0:0]       m_axis_tuser,   // [0] saturated
  // Coefficient writes.
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_addr_i,
  input  wire logic [31:0] cfg_wdata_i
);

  biq_cmd_t           cmd;
  logic signed [15:0] sample_out;
  logic               sat;

  biq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_mode_i   (s_axis_tuser[0]),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .cmd_o       (cmd)
  );

  biq_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sample_i    (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sample_o    (sample_out),
    .sat_o       (sat)
  );

  assign m_axis_tdata    = sample_out;
  assign m_axis_tuser[0] = sat;

endmodule

`default_nettype wire
